// ===== src/assert_macros.svh =====
// Concurrent assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never hold at a clock edge.
`define ASSERT_NEVER(label, cond, msg) \
	`ASSERT_CLK(label, !(cond), msg)

`endif

// ===== src/upd_pkg.sv =====
// Types, constants and byte classification helpers for the URL percent decoder.
package upd_pkg;

	localparam int unsigned MAX_LENGTH = 32'd65535;
	localparam logic [15:0] LEN_LIMIT  = (MAX_LENGTH < 32'd65535) ? 16'(MAX_LENGTH) : 16'hFFFF;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SEMI    = 8'h3B;
	localparam logic [7:0] CH_QUEST   = 8'h3F;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] STOP_RESET = 8'h3D;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;
	localparam int NUM_SLOTS  = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATH_MODE = 1'b0,
		REG_STOP_BYTE = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_string;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        byte_valid;
		logic        segment_done;
		logic [15:0] consumed_length;
		logic        last_result;
	} out_item_t;

	// outcome of handling one byte outside an escape
	typedef struct packed {
		logic       emit;
		logic [7:0] ebyte;
		logic       stop;
		logic       set_pct;
		logic       set_skip;
	} hres_t;

	// bit 4 set: not a hex digit
	function automatic logic [4:0] hexval(input logic [7:0] c);
		logic [4:0] v;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = {1'b0, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = {1'b0, 4'(c - 8'h37)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = {1'b0, 4'(c - 8'h57)};
		end else begin
			v = 5'h10;
		end
		return v;
	endfunction

	function automatic hres_t handle_byte(input logic [7:0] b, input logic skip,
			input logic path_mode, input logic [7:0] stop_byte);
		hres_t r;
		r = '0;
		if (skip) begin
			r.stop = (b == CH_QUEST);
		end else if (b == CH_PERCENT) begin
			r.set_pct = 1'b1;
		end else if (path_mode) begin
			if (b == CH_QUEST) begin
				r.stop = 1'b1;
			end else if (b == CH_SEMI) begin
				r.set_skip = 1'b1;
			end else begin
				r.emit  = 1'b1;
				r.ebyte = b;
			end
		end else begin
			if (b == stop_byte) begin
				r.stop = 1'b1;
			end else begin
				r.emit  = 1'b1;
				r.ebyte = (b == CH_PLUS) ? CH_SPACE : b;
			end
		end
		return r;
	endfunction

endpackage

// ===== src/url_percent_decoder.sv =====
// Latency: a byte's first result is offered the cycle after its input transfer.
// Throughput: one byte per cycle while each byte yields at most one result and out_stall
//   is low; a byte yielding k results (k up to 3, broken escapes) stalls input until its
//   final result is being taken. The 3-entry result buffer sets this.
// Reset (arst_n low, async): escape/skip/stop state and length count cleared,
//   path_mode = 0, stop_byte = '=', result buffer empty.
`include "assert_macros.svh"

module url_percent_decoder (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [upd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [upd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  upd_pkg::in_item_t                   in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output upd_pkg::out_item_t                  out_data
);
	import upd_pkg::*;

	// configuration
	logic       path_mode_q;
	logic [7:0] stop_byte_q;

	// per-string decode state
	logic        pct_q;       // '%' seen, escape open
	logic        fdv_q;       // first hex digit held
	logic [7:0]  first_q;     // held digit, raw
	logic        skip_q;      // inside matrix parameters
	logic        stopped_q;   // segment ended, dropping until end of string
	logic [15:0] count_q;

	// result buffer: entry 0 is the one on offer
	out_item_t   res_q [NUM_SLOTS];
	logic [1:0]  cnt_q;

	logic accept, take;

	// next-state and results of the byte being accepted
	logic [4:0]  hex_b, hex_h;
	logic        b_is_hex, eos;
	logic        case_a, case_b, hold_digit, broken_b, held_stop, hb_call;
	logic        stop_any, done, pct_next, skip_next;
	hres_t       hh, hb;
	logic [15:0] newc, len;
	logic [3:0]  cand_v;
	logic [7:0]  cand_b [4];
	out_item_t   slot [NUM_SLOTS];
	logic [1:0]  n, nres, last_idx;

	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = res_q[0];
	assign take      = out_valid && !out_stall;
	// room when the buffer is empty or drains its last entry this cycle
	assign in_stall  = !((cnt_q == 2'd0) || (cnt_q == 2'd1 && !out_stall));
	assign accept    = in_valid && !in_stall;

	always_comb begin
		eos      = in_data.end_of_string;
		hex_b    = hexval(in_data.in_byte);
		hex_h    = hexval(first_q);
		b_is_hex = !hex_b[4];
		newc     = (count_q >= LEN_LIMIT) ? LEN_LIMIT : count_q + 16'd1;

		case_a     = pct_q && !fdv_q;
		case_b     = pct_q && fdv_q;
		hold_digit = case_a && b_is_hex && !eos;
		broken_b   = case_b && !b_is_hex;

		// held digit is never special but may equal the stop byte
		hh = handle_byte(first_q, 1'b0, path_mode_q, stop_byte_q);
		hb = handle_byte(in_data.in_byte, skip_q, path_mode_q, stop_byte_q);

		held_stop = broken_b && hh.stop;
		hb_call   = !pct_q || (case_a && !hold_digit) || (broken_b && !hh.stop);
		stop_any  = held_stop || (hb_call && hb.stop);
		pct_next  = hold_digit || (hb_call && hb.set_pct);
		skip_next = skip_q || (hb_call && hb.set_skip);
		done      = stop_any || eos;
		len       = held_stop ? count_q : newc;

		// candidate bytes in emission order
		cand_v[0] = (case_a && !hold_digit) || broken_b;
		cand_b[0] = CH_PERCENT;
		cand_v[1] = (case_b && b_is_hex) || (broken_b && !hh.stop);
		cand_b[1] = b_is_hex ? {hex_h[3:0], hex_b[3:0]} : first_q;
		cand_v[2] = hb_call && hb.emit;
		cand_b[2] = hb.ebyte;
		// escape left open by the final byte goes out literally
		cand_v[3] = eos && !stop_any && pct_next;
		cand_b[3] = CH_PERCENT;

		for (int s = 0; s < NUM_SLOTS; s++) begin
			slot[s] = '0;
		end
		n = 2'd0;
		for (int k = 0; k < 4; k++) begin
			if (cand_v[k] && n != 2'd3) begin
				slot[n].out_byte   = cand_b[k];
				slot[n].byte_valid = 1'b1;
				n = n + 2'd1;
			end
		end

		// done marker rides on the last byte, else stands alone
		if (stopped_q) begin
			nres = 2'd0;
		end else if (n == 2'd0 && done) begin
			nres = 2'd1;
		end else begin
			nres = n;
		end
		last_idx = nres - 2'd1;
		if (nres != 2'd0) begin
			slot[last_idx].last_result     = 1'b1;
			slot[last_idx].segment_done    = done;
			slot[last_idx].consumed_length = done ? len : 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			path_mode_q <= 1'b0;
			stop_byte_q <= STOP_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PATH_MODE: path_mode_q <= cfg_wdata[0];
				REG_STOP_BYTE: stop_byte_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pct_q     <= 1'b0;
			fdv_q     <= 1'b0;
			skip_q    <= 1'b0;
			stopped_q <= 1'b0;
			count_q   <= '0;
		end else if (accept) begin
			if (eos) begin
				// end of string: fresh start for the next one
				pct_q     <= 1'b0;
				fdv_q     <= 1'b0;
				skip_q    <= 1'b0;
				stopped_q <= 1'b0;
				count_q   <= '0;
			end else if (!stopped_q) begin
				pct_q     <= pct_next;
				fdv_q     <= hold_digit;
				skip_q    <= skip_next;
				stopped_q <= stop_any;
				count_q   <= newc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && hold_digit && !stopped_q) begin
			first_q <= in_data.in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (accept) begin
			cnt_q <= nres;
		end else if (take) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// transfer out shifts the buffer; an accept refills it whole
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int s = 0; s < NUM_SLOTS; s++) begin
				res_q[s] <= slot[s];
			end
		end else if (take) begin
			for (int s = 0; s < NUM_SLOTS - 1; s++) begin
				res_q[s] <= res_q[s+1];
			end
		end
	end

	`ASSERT_CLK(a_last_on_final, out_valid |-> (out_data.last_result == (cnt_q == 2'd1)), "last_result not on final buffered entry")
	`ASSERT_NEVER(a_done_not_last, out_valid && out_data.segment_done && !out_data.last_result, "segment_done before last result")
	`ASSERT_CLK(a_marker_only, out_valid && !out_data.byte_valid |-> out_data.segment_done && out_data.out_byte == 8'd0, "empty result without done")
	`ASSERT_CLK(a_len_with_done, out_valid && !out_data.segment_done |-> out_data.consumed_length == 16'd0, "length without done")
	`ASSERT_CLK(a_drop_silent, accept && stopped_q |=> cnt_q == 2'd0, "dropped byte produced a result")

endmodule
